### rtl/cubic_bezier_subdivider_unit_macros.svh
// Assertion macros for the cubic Bezier subdivider.
// No dependencies; taken in by the checker file.
`ifndef CUBIC_BEZIER_SUBDIVIDER_UNIT_MACROS_SVH
`define CUBIC_BEZIER_SUBDIVIDER_UNIT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define CBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cbs check failed");

// Consequent must hold in the same cycle as the antecedent.
`define CBS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cbs check failed");

`endif

### rtl/cbs_pkg.sv
// Shared types and constants for the cubic Bezier subdivider.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cbs_pkg;
    localparam int CURVE_WORDS = 12;
    localparam int LEVEL_BITS  = 3;
    localparam int CNT_BITS    = 8;
    localparam logic [LEVEL_BITS-1:0] LEVEL_RESET = 3'd4;

    // word offsets of the four points inside a curve
    localparam int P0_OFS = 0;
    localparam int P1_OFS = 3;
    localparam int P2_OFS = 6;
    localparam int P3_OFS = 9;

    typedef struct packed {
        logic                  adv;
        logic [CNT_BITS-1:0]   step;
        logic [LEVEL_BITS-1:0] lev;
    } cbs_ctrl_t;
endpackage
`default_nettype wire

### rtl/cbs_ifaces.sv
// Valid/ready channel interfaces for curves in and segments out.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface cbs_curve_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] start_x, start_y, start_z;
    logic signed [W-1:0] finish_x, finish_y, finish_z;
    logic signed [W-1:0] ctrl_near_start_x, ctrl_near_start_y, ctrl_near_start_z;
    logic signed [W-1:0] ctrl_near_finish_x, ctrl_near_finish_y, ctrl_near_finish_z;
    modport source (output valid, start_x, start_y, start_z, finish_x, finish_y,
                    finish_z, ctrl_near_start_x, ctrl_near_start_y, ctrl_near_start_z,
                    ctrl_near_finish_x, ctrl_near_finish_y, ctrl_near_finish_z,
                    input ready);
    modport sink   (input valid, start_x, start_y, start_z, finish_x, finish_y,
                    finish_z, ctrl_near_start_x, ctrl_near_start_y, ctrl_near_start_z,
                    ctrl_near_finish_x, ctrl_near_finish_y, ctrl_near_finish_z,
                    output ready);
endinterface

interface cbs_seg_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] seg_begin_x, seg_begin_y, seg_begin_z;
    logic signed [W-1:0] seg_end_x, seg_end_y, seg_end_z;
    logic                last_segment;
    modport source (output valid, seg_begin_x, seg_begin_y, seg_begin_z, seg_end_x,
                    seg_end_y, seg_end_z, last_segment, input ready);
    modport sink   (input valid, seg_begin_x, seg_begin_y, seg_begin_z, seg_end_x,
                    seg_end_y, seg_end_z, last_segment, output ready);
endinterface
`default_nettype wire

### rtl/cbs_halver.sv
// De Casteljau halving of one cubic curve at t = 1/2, three axes in parallel.
// Depends on cbs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cbs_halver
    import cbs_pkg::*;
#(
    parameter int W = 32
)
(
    input  wire logic [CURVE_WORDS-1:0][W-1:0] curve,
    output logic      [CURVE_WORDS-1:0][W-1:0] left_half,
    output logic      [CURVE_WORDS-1:0][W-1:0] right_half
);
    // floor((a + b) / 2) through a sign-widened add
    function automatic logic [W-1:0] mid(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        return s[W:1];
    endfunction

    for (genvar k = 0; k < 3; k++) begin : g_axis
        logic [W-1:0] m01, m12, m23, m012, m123, m;
        assign m01  = mid(curve[P0_OFS+k], curve[P1_OFS+k]);
        assign m12  = mid(curve[P1_OFS+k], curve[P2_OFS+k]);
        assign m23  = mid(curve[P2_OFS+k], curve[P3_OFS+k]);
        assign m012 = mid(m01, m12);
        assign m123 = mid(m12, m23);
        assign m    = mid(m012, m123);
        assign left_half[P0_OFS+k]  = curve[P0_OFS+k];
        assign left_half[P1_OFS+k]  = m01;
        assign left_half[P2_OFS+k]  = m012;
        assign left_half[P3_OFS+k]  = m;
        assign right_half[P0_OFS+k] = m;
        assign right_half[P1_OFS+k] = m123;
        assign right_half[P2_OFS+k] = m23;
        assign right_half[P3_OFS+k] = curve[P3_OFS+k];
    end
endmodule
`default_nettype wire

### rtl/cbs_cell.sv
// One level cell: halves the curve from its upstream neighbor, keeps the right
// half pending and hands left then right downstream. Depends on cbs_pkg, cbs_halver.
`timescale 1ns / 1ps
`default_nettype none
module cbs_cell
    import cbs_pkg::*;
#(
    parameter int W         = 32,
    parameter int MAX_LEVEL = 6,
    parameter int IDX       = 0
)
(
    input  wire logic                             clk,
    input  wire cbs_ctrl_t                        ctrl,
    input  wire logic [CURVE_WORDS-1:0][W-1:0]    curve_in,
    output logic      [CURVE_WORDS-1:0][W-1:0]    curve_out
);
    localparam int B = MAX_LEVEL - 1 - IDX;
    localparam logic [CNT_BITS-1:0] LOW_MASK = CNT_BITS'((1 << B) - 1);

    logic [CURVE_WORDS-1:0][W-1:0] out_reg, out_next;
    logic [CURVE_WORDS-1:0][W-1:0] pend_reg, pend_next;
    logic [CURVE_WORDS-1:0][W-1:0] lh, rh;
    logic [CNT_BITS-1:0] idx;
    logic                active, low_zero, split_en;

    cbs_halver #(.W(W)) u_halver (.curve(curve_in), .left_half(lh), .right_half(rh));

    always_comb
    begin
        idx      = ctrl.step - CNT_BITS'(IDX);
        active   = ctrl.adv && (ctrl.step >= CNT_BITS'(IDX))
                   && (idx < (CNT_BITS'(1) << ctrl.lev));
        low_zero = (idx & LOW_MASK) == '0;
        // cells in front of the active ones pass the curve through
        split_en = (CNT_BITS'(ctrl.lev) + CNT_BITS'(IDX)) >= CNT_BITS'(MAX_LEVEL);
        out_next  = out_reg;
        pend_next = pend_reg;
        if (active && low_zero)
        begin
            if (!split_en)
            begin
                out_next = curve_in;
            end
            else if (!idx[B])
            begin
                out_next  = lh;
                pend_next = rh;
            end
            else
            begin
                out_next = pend_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

    assign curve_out = out_reg;
endmodule
`default_nettype wire

### rtl/cubic_bezier_subdivider_unit.sv
// Top level of the cubic Bezier subdivider: input capture, cell chain, sequencer.
// Depends on cbs_pkg, cbs_ifaces, cbs_cell.
//
// Channel   Dir  Handshake       Payload
// curve     in   valid/ready     start, finish, two control points (x,y,z each)
// seg       out  valid/ready     segment begin/end (x,y,z), last_segment
// cfg_wr    in   write enable    subdivision_level, 3 bits
//
// A curve is taken in its transfer, then the chain advances: first it fills the
// cell chain, then it gives one segment per cycle while seg is not stalled.
// Reset (rst_n low, async) clears the sequencer and sets the level to 4.
// A stall on seg freezes the whole chain; the next curve transfer is taken as
// soon as the sequencer is done, even while the final segment still waits.
`timescale 1ns / 1ps
`default_nettype none
module cubic_bezier_subdivider_unit
    import cbs_pkg::*;
#(
    parameter int MAX_LEVEL  = 6,
    parameter int COORD_BITS = 32
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    cbs_curve_if.sink                  curve,
    cbs_seg_if.source                  seg,
    input  wire logic                  cfg_wr_en,
    input  wire logic [LEVEL_BITS-1:0] cfg_wr_data
);
    localparam int W = COORD_BITS;

    logic                  busy_reg, busy_next;
    logic [CNT_BITS-1:0]   step_reg, step_next;
    logic [LEVEL_BITS-1:0] level_reg;
    logic                  seg_valid_reg, seg_valid_next;
    logic                  last_reg, last_next;
    logic [CURVE_WORDS-1:0][W-1:0] in_reg;
    logic [MAX_LEVEL:0][CURVE_WORDS-1:0][W-1:0] chain;

    logic                  accept, adv, leaf_now;
    logic [LEVEL_BITS-1:0] lev;
    logic [CNT_BITS-1:0]   leaf_idx, leaf_count, step_end;
    cbs_ctrl_t             ctrl;

    // saturate the level to what the chain can hold
    assign lev = (level_reg > LEVEL_BITS'(MAX_LEVEL)) ? LEVEL_BITS'(MAX_LEVEL) : level_reg;

    assign accept      = curve.valid && curve.ready;
    assign curve.ready = !busy_reg;
    // advance only when the output register can take what the chain produces
    assign adv         = busy_reg && (!seg_valid_reg || seg.ready);

    always_comb
    begin
        leaf_count = CNT_BITS'(1) << lev;
        step_end   = leaf_count + CNT_BITS'(MAX_LEVEL) - CNT_BITS'(2);
        leaf_idx   = step_reg - CNT_BITS'(MAX_LEVEL - 1);
        leaf_now   = adv && (step_reg >= CNT_BITS'(MAX_LEVEL - 1)) && (leaf_idx < leaf_count);
        ctrl.adv   = adv;
        ctrl.step  = step_reg;
        ctrl.lev   = lev;

        busy_next      = busy_reg;
        step_next      = step_reg;
        seg_valid_next = seg_valid_reg;
        last_next      = last_reg;
        if (seg_valid_reg && seg.ready)
        begin
            seg_valid_next = 1'b0;
        end
        if (adv)
        begin
            // the last cell loads its leaf on this edge; show it next cycle
            seg_valid_next = leaf_now;
            last_next      = leaf_idx == (leaf_count - CNT_BITS'(1));
            if (step_reg == step_end)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                step_next = step_reg + CNT_BITS'(1);
            end
        end
        if (accept)
        begin
            busy_next = 1'b1;
            step_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            level_reg     <= LEVEL_RESET;
            seg_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            seg_valid_reg <= seg_valid_next;
            last_reg      <= last_next;
            if (cfg_wr_en)
            begin
                level_reg <= cfg_wr_data;
            end
        end
    end

    // capture the curve in point order P0, P1, P2, P3
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg[P0_OFS+0] <= curve.start_x;
            in_reg[P0_OFS+1] <= curve.start_y;
            in_reg[P0_OFS+2] <= curve.start_z;
            in_reg[P1_OFS+0] <= curve.ctrl_near_start_x;
            in_reg[P1_OFS+1] <= curve.ctrl_near_start_y;
            in_reg[P1_OFS+2] <= curve.ctrl_near_start_z;
            in_reg[P2_OFS+0] <= curve.ctrl_near_finish_x;
            in_reg[P2_OFS+1] <= curve.ctrl_near_finish_y;
            in_reg[P2_OFS+2] <= curve.ctrl_near_finish_z;
            in_reg[P3_OFS+0] <= curve.finish_x;
            in_reg[P3_OFS+1] <= curve.finish_y;
            in_reg[P3_OFS+2] <= curve.finish_z;
        end
    end

    assign chain[0] = in_reg;

    // one cell per halving level; unused front cells pass the curve along
    for (genvar k = 0; k < MAX_LEVEL; k++) begin : g_cell
        cbs_cell #(.W(W), .MAX_LEVEL(MAX_LEVEL), .IDX(k)) u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .curve_in (chain[k]),
            .curve_out(chain[k+1])
        );
    end

    // the last cell's register is the segment output register
    assign seg.valid        = seg_valid_reg;
    assign seg.last_segment = last_reg;
    assign seg.seg_begin_x  = chain[MAX_LEVEL][P0_OFS+0];
    assign seg.seg_begin_y  = chain[MAX_LEVEL][P0_OFS+1];
    assign seg.seg_begin_z  = chain[MAX_LEVEL][P0_OFS+2];
    assign seg.seg_end_x    = chain[MAX_LEVEL][P3_OFS+0];
    assign seg.seg_end_y    = chain[MAX_LEVEL][P3_OFS+1];
    assign seg.seg_end_z    = chain[MAX_LEVEL][P3_OFS+2];
endmodule
`default_nettype wire

### rtl/cbs_checker.sv
// Port-level checks for the cubic Bezier subdivider, bound to the top level.
// Depends on cubic_bezier_subdivider_unit_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "cubic_bezier_subdivider_unit_macros.svh"
module cbs_checker #(
    parameter int W = 32
)
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         in_valid,
    input wire logic         in_ready,
    input wire logic         out_valid,
    input wire logic         out_ready,
    input wire logic [W-1:0] out_begin_x,
    input wire logic         out_last
);
    `CBS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_begin_x) && $stable(out_last))
    `CBS_ASSERT_NEXT(a_in_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)
    `CBS_ASSERT_NEXT(a_no_instant_seg, clk, rst_n, in_valid && in_ready, !$rose(out_valid))
    `CBS_ASSERT_SAME(a_idle_means_done, clk, rst_n, in_ready && out_valid, out_last)
endmodule

bind cubic_bezier_subdivider_unit cbs_checker #(.W(COORD_BITS)) u_cbs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (curve.valid),
    .in_ready   (curve.ready),
    .out_valid  (seg.valid),
    .out_ready  (seg.ready),
    .out_begin_x(seg.seg_begin_x),
    .out_last   (seg.last_segment)
);
`default_nettype wire

### tb/cbs_tb_ifaces.sv
// Testbench-side view of the curve and segment channels.
// No dependencies; the RTL interfaces (cbs_curve_if, cbs_seg_if) live in cbs_ifaces.
`timescale 1ns / 1ps
`default_nettype none
// The RTL interfaces already carry source and sink modports; this file only
// holds the curve and segment records used by the bench for pending transfers.
package cbs_tb_types;
    typedef struct packed {
        logic signed [31:0] sx, sy, sz;
        logic signed [31:0] fx, fy, fz;
        logic signed [31:0] ax, ay, az;
        logic signed [31:0] bx, by, bz;
    } curve_rec_t;

    typedef struct packed {
        logic signed [31:0] bx, by, bz;
        logic signed [31:0] ex, ey, ez;
        logic               last;
    } seg_rec_t;
endpackage
`default_nettype wire

### tb/cubic_bezier_subdivider_unit_test.sv
// Self-checking bench for cubic_bezier_subdivider_unit: random and directed curves,
// level sweeps, random stalls on both channels. Depends on cbs_pkg, cbs_ifaces,
// cbs_tb_types.
`timescale 1ns / 1ps
`default_nettype none
module cubic_bezier_subdivider_unit_test;
    import cbs_pkg::*;
    import cbs_tb_types::*;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [LEVEL_BITS-1:0] cfg_wr_data;

    cbs_curve_if #(32) curve ();
    cbs_seg_if   #(32) seg ();

    cubic_bezier_subdivider_unit #(.MAX_LEVEL(6), .COORD_BITS(32)) uut
    (
        .clk(clk), .rst_n(rst_n), .curve(curve), .seg(seg),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    // Curves waiting to be driven, segments waiting to be seen.
    curve_rec_t pending_curves[$];
    seg_rec_t   expected_segs[$];
    int         error_count = 0;
    bit         quiet_tail = 0;     // no idling in the last part of the run
    int         src_gap = 0;
    int         snk_gap = 0;
    logic [2:0] level_shadow = 3'd4;

    typedef logic signed [32:0] wide_t;
    typedef wide_t curve_pts_t [12];

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // Floor of the average: widened add, arithmetic shift right by one.
    function automatic wide_t mid(wide_t a, wide_t b);
        logic signed [33:0] s;
        s = a + b;
        return wide_t'(s >>> 1);
    endfunction

    // Split a curve into its de Casteljau halves, then recurse depth first,
    // left half first, and queue one segment per leaf.
    function automatic void split_into_segs(curve_pts_t c, int lev, bit is_tail);
        curve_pts_t lh;
        curve_pts_t rh;
        seg_rec_t   s;
        wide_t      m01, m12, m23, m012, m123, m;
        if (lev == 0)
        begin
            s.bx = c[0][31:0]; s.by = c[1][31:0]; s.bz = c[2][31:0];
            s.ex = c[9][31:0]; s.ey = c[10][31:0]; s.ez = c[11][31:0];
            s.last = is_tail;
            expected_segs.push_back(s);
            return;
        end
        for (int k = 0; k < 3; k++)
        begin
            m01  = mid(c[k], c[3+k]);
            m12  = mid(c[3+k], c[6+k]);
            m23  = mid(c[6+k], c[9+k]);
            m012 = mid(m01, m12);
            m123 = mid(m12, m23);
            m    = mid(m012, m123);
            lh[k] = c[k]; lh[3+k] = m01;  lh[6+k] = m012; lh[9+k] = m;
            rh[k] = m;    rh[3+k] = m123; rh[6+k] = m23;  rh[9+k] = c[9+k];
        end
        split_into_segs(lh, lev - 1, 1'b0);
        split_into_segs(rh, lev - 1, is_tail);
    endfunction

    function automatic void predict_segments(curve_rec_t r);
        curve_pts_t c;
        int lev;
        lev = (level_shadow > 6) ? 6 : level_shadow;
        c[0] = r.sx; c[1] = r.sy; c[2] = r.sz;
        c[3] = r.ax; c[4] = r.ay; c[5] = r.az;
        c[6] = r.bx; c[7] = r.by; c[8] = r.bz;
        c[9] = r.fx; c[10] = r.fy; c[11] = r.fz;
        split_into_segs(c, lev, 1'b1);
    endfunction

    // Driver: present the head of the queue; advance on each transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curve.valid <= 1'b0;
            src_gap     <= 0;
        end
        else
        begin
            if (curve.valid && curve.ready)
            begin
                predict_segments(pending_curves.pop_front());
            end
            if (curve.valid && !curve.ready)
            begin
                // hold the item until it is taken
            end
            else if (src_gap > 0)
            begin
                curve.valid <= 1'b0;
                src_gap     <= src_gap - 1;
            end
            else if (pending_curves.size() > 0 && !cfg_wr_en)
            begin
                if (!quiet_tail && $urandom_range(0, 5) == 0)
                begin
                    curve.valid <= 1'b0;
                    src_gap     <= $urandom_range(1, 11);
                end
                else
                begin
                    curve.valid              <= 1'b1;
                    curve.start_x            <= pending_curves[0].sx;
                    curve.start_y            <= pending_curves[0].sy;
                    curve.start_z            <= pending_curves[0].sz;
                    curve.finish_x           <= pending_curves[0].fx;
                    curve.finish_y           <= pending_curves[0].fy;
                    curve.finish_z           <= pending_curves[0].fz;
                    curve.ctrl_near_start_x  <= pending_curves[0].ax;
                    curve.ctrl_near_start_y  <= pending_curves[0].ay;
                    curve.ctrl_near_start_z  <= pending_curves[0].az;
                    curve.ctrl_near_finish_x <= pending_curves[0].bx;
                    curve.ctrl_near_finish_y <= pending_curves[0].by;
                    curve.ctrl_near_finish_z <= pending_curves[0].bz;
                end
            end
            else
            begin
                curve.valid <= 1'b0;
            end
        end
    end

    // Monitor: random backpressure on seg, compare each transfer in order.
    always @(posedge clk or negedge rst_n)
    begin
        seg_rec_t e;
        if (!rst_n)
        begin
            seg.ready <= 1'b0;
            snk_gap   <= 0;
        end
        else
        begin
            if (seg.valid && seg.ready)
            begin
                if (expected_segs.size() == 0)
                begin
                    $error("segment with nothing expected");
                    error_count++;
                end
                else
                begin
                    e = expected_segs.pop_front();
                    if (seg.seg_begin_x !== e.bx)
                    begin
                        $error("seg_begin_x exp %0d got %0d", e.bx, seg.seg_begin_x);
                        error_count++;
                    end
                    if (seg.seg_begin_y !== e.by)
                    begin
                        $error("seg_begin_y exp %0d got %0d", e.by, seg.seg_begin_y);
                        error_count++;
                    end
                    if (seg.seg_begin_z !== e.bz)
                    begin
                        $error("seg_begin_z exp %0d got %0d", e.bz, seg.seg_begin_z);
                        error_count++;
                    end
                    if (seg.seg_end_x !== e.ex)
                    begin
                        $error("seg_end_x exp %0d got %0d", e.ex, seg.seg_end_x);
                        error_count++;
                    end
                    if (seg.seg_end_y !== e.ey)
                    begin
                        $error("seg_end_y exp %0d got %0d", e.ey, seg.seg_end_y);
                        error_count++;
                    end
                    if (seg.seg_end_z !== e.ez)
                    begin
                        $error("seg_end_z exp %0d got %0d", e.ez, seg.seg_end_z);
                        error_count++;
                    end
                    if (seg.last_segment !== e.last)
                    begin
                        $error("last_segment exp %0d got %0d", e.last, seg.last_segment);
                        error_count++;
                    end
                end
            end
            if (snk_gap > 0)
            begin
                seg.ready <= 1'b0;
                snk_gap   <= snk_gap - 1;
            end
            else if (!quiet_tail && $urandom_range(0, 7) == 0)
            begin
                seg.ready <= 1'b0;
                snk_gap   <= $urandom_range(1, 11);
            end
            else
            begin
                seg.ready <= 1'b1;
            end
        end
    end

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return $urandom_range(0, 255) << 16;   // whole-number coordinates
            default: return $urandom;
        endcase
    endfunction

    function automatic curve_rec_t random_curve();
        curve_rec_t r;
        r = {pick_coord(), pick_coord(), pick_coord(), pick_coord(),
             pick_coord(), pick_coord(), pick_coord(), pick_coord(),
             pick_coord(), pick_coord(), pick_coord(), pick_coord()};
        return r;
    endfunction

    function automatic curve_rec_t flat_curve(logic [31:0] v);
        curve_rec_t r;
        r = {12{v}};
        return r;
    endfunction

    // Wait until every queued curve is taken and every segment seen, then
    // let the sequencer drain before touching the level register.
    task automatic drain_all();
        while (pending_curves.size() > 0 || curve.valid || expected_segs.size() > 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_level(logic [2:0] lv);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= lv;
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
        level_shadow  = lv;
    endtask

    initial
    begin
        logic [2:0] lv_plan[$];
        curve_rec_t r;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        curve.valid = 1'b0;
        {curve.start_x, curve.start_y, curve.start_z} = '0;
        {curve.finish_x, curve.finish_y, curve.finish_z} = '0;
        {curve.ctrl_near_start_x, curve.ctrl_near_start_y, curve.ctrl_near_start_z} = '0;
        {curve.ctrl_near_finish_x, curve.ctrl_near_finish_y,
         curve.ctrl_near_finish_z} = '0;
        seg.ready = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset level, extremes of every coordinate.
        pending_curves.push_back(flat_curve(32'h8000_0000));
        pending_curves.push_back(flat_curve(32'h7fff_ffff));
        pending_curves.push_back(flat_curve(32'h0000_0000));
        r = flat_curve(32'h7fff_ffff);
        r.fx = 32'h8000_0000; r.fy = 32'h8000_0000; r.fz = 32'h8000_0000;
        r.bx = 32'h8000_0000; r.by = 32'h8000_0000; r.bz = 32'h8000_0000;
        pending_curves.push_back(r);
        pending_curves.push_back(~r);
        drain_all();

        // Level zero gives the chord; above MAX_LEVEL saturates; then the rest.
        lv_plan = '{3'd0, 3'd7, 3'd6, 3'd1, 3'd2, 3'd3, 3'd5, 3'd4, 3'd0, 3'd6};
        foreach (lv_plan[i])
        begin
            write_level(lv_plan[i]);
            for (int n = 0; n < ((i < 2) ? 3 : 10); n++)
                pending_curves.push_back(random_curve());
            if (i == lv_plan.size() - 1)
                quiet_tail = 1;
            drain_all();
        end

        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire

### cubic_bezier_subdivider_unit.f
+incdir+rtl
rtl/cbs_pkg.sv
rtl/cbs_ifaces.sv
rtl/cbs_halver.sv
rtl/cbs_cell.sv
rtl/cubic_bezier_subdivider_unit.sv
rtl/cbs_checker.sv
tb/cbs_tb_ifaces.sv
tb/cubic_bezier_subdivider_unit_test.sv
